[rtl/vertex_transform_4x4_unit_macros.svh]
// Assertion macros shared by the vertex transform checker.
`ifndef VERTEX_TRANSFORM_4X4_UNIT_MACROS_SVH
`define VERTEX_TRANSFORM_4X4_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define VT4_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vt4: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define VT4_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vt4: next-cycle check failed");

`endif

[rtl/vt4_pkg.sv]
// Shared types, constants and helpers of the 4x4 vertex transform.
package vt4_pkg;

  // Configuration register file
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);
  localparam int unsigned REG_W     = 64;

  // Matrix and vector geometry
  localparam int unsigned ELEM_W    = 32;
  localparam int unsigned VEC_LEN   = 4;
  localparam int unsigned NUM_ELEMS = VEC_LEN * VEC_LEN;

  // Datapath widths: product, pair sum, full dot-product sum
  localparam int unsigned PROD_W = 2 * ELEM_W;
  localparam int unsigned PSUM_W = PROD_W + 1;
  localparam int unsigned SUM_W  = PROD_W + 2;

  // Pipeline depth: products, pair sums, full sum, shift and clip
  localparam int unsigned STAGES = 4;

  localparam int unsigned FRAC_BITS_DEF = 16;

  // Clip values
  localparam logic [ELEM_W-1:0] SAT_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] SAT_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef elem_t [VEC_LEN-1:0]      vec_t;
  typedef elem_t [NUM_ELEMS-1:0]    coef_mat_t;

  // Per-stage register load strobes from the pipeline control
  typedef struct packed {
    logic [STAGES-1:0] load;
  } ctrl_t;

  // Reset contents of one coefficient pair: identity matrix, 1.0 = 1 << frac
  function automatic logic [REG_W-1:0] reset_pair(int unsigned k, int unsigned frac);
    logic [REG_W-1:0] r;
    int unsigned      e;
    r = '0;
    for (int unsigned h = 0; h < 2; h++) begin
      e = 2 * k + h;
      if ((e >> 2) == (e & 3)) begin
        r[h*ELEM_W +: ELEM_W] = ELEM_W'(1) << frac;
      end
    end
    return r;
  endfunction

endpackage

[rtl/vt4_pipe_ctrl.sv]
// Valid/ready control of the transform pipeline: per-stage valid bits and load strobes.
module vt4_pipe_ctrl import vt4_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output ctrl_t ctrl_o
);

  logic [STAGES-1:0] valid_q, valid_d;
  logic [STAGES-1:0] valid_prev;
  logic [STAGES:0]   ready;

  // Valid bit feeding each stage
  assign valid_prev = {valid_q[STAGES-2:0], in_valid_i};

  // A stage takes new data when it is empty or its successor takes its contents
  always_comb begin
    ready[STAGES] = out_ready_i;
    for (int k = STAGES - 1; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
    for (int k = 0; k < STAGES; k++) begin
      valid_d[k] = ready[k] ? valid_prev[k] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ctrl_o.load = ready[STAGES-1:0];
  assign in_ready_o  = ready[0];
  assign out_valid_o = valid_q[STAGES-1];

endmodule

[rtl/vt4_coef_regs.sv]
// Coefficient register file: eight 64-bit pairs holding the column-major matrix.
module vt4_coef_regs import vt4_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_data_i,
  output coef_mat_t            coef_o
);

  logic [NUM_REGS-1:0][REG_W-1:0] pair_q;

  // Register writes; reset loads the identity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned k = 0; k < NUM_REGS; k++) begin
        pair_q[k] <= reset_pair(k, FRAC_BITS);
      end
    end else if (cfg_we_i) begin
      pair_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Element 2k in the low half of pair k, element 2k+1 in the high half
  always_comb begin
    for (int unsigned e = 0; e < NUM_ELEMS; e++) begin
      coef_o[e] = pair_q[e >> 1][(e & 1) * ELEM_W +: ELEM_W];
    end
  end

endmodule

[rtl/vt4_dot_lane.sv]
// One output component: four products, adder tree, shift and clip over four stages.
module vt4_dot_lane import vt4_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  ctrl_t             ctrl_i,
  input  vec_t              vec_i,
  input  vec_t              coef_i,
  output logic [ELEM_W-1:0] res_o,
  output logic              sat_o
);

  logic signed [PROD_W-1:0] prod_q [VEC_LEN];
  logic signed [PSUM_W-1:0] psum_q [2];
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [SUM_W-1:0]  shifted;
  logic                     ovf;
  logic [ELEM_W-1:0]        res_q;
  logic                     sat_q;

  // Stage 1: one 32x32 signed multiply per component
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[0]) begin
      for (int j = 0; j < VEC_LEN; j++) begin
        prod_q[j] <= PROD_W'(vec_i[j]) * PROD_W'(coef_i[j]);
      end
    end
  end

  // Stage 2: pair sums, one guard bit
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[1]) begin
      psum_q[0] <= {prod_q[0][PROD_W-1], prod_q[0]} + {prod_q[1][PROD_W-1], prod_q[1]};
      psum_q[1] <= {prod_q[2][PROD_W-1], prod_q[2]} + {prod_q[3][PROD_W-1], prod_q[3]};
    end
  end

  // Stage 3: exact full sum
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[2]) begin
      sum_q <= {psum_q[0][PSUM_W-1], psum_q[0]} + {psum_q[1][PSUM_W-1], psum_q[1]};
    end
  end

  // Stage 4: floor shift, then clip to 32 bits when the upper bits are not all sign
  assign shifted = sum_q >>> FRAC_BITS;
  assign ovf     = !((&shifted[SUM_W-1:ELEM_W-1]) || !(|shifted[SUM_W-1:ELEM_W-1]));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[3]) begin
      res_q <= ovf ? (shifted[SUM_W-1] ? SAT_MIN : SAT_MAX) : shifted[ELEM_W-1:0];
      sat_q <= ovf;
    end
  end

  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule

[rtl/vertex_transform_4x4_unit.sv]
// Top level of the 4x4 homogeneous vertex transform.
// Transforms one vertex (x, y, z, w) per clock by the column-major matrix in coef_pair_0..7
// (index 0..7 on cfg_idx_i; element 2k low half, 2k+1 high half; identity after reset).
// Every transaction passes four register stages: one for the sixteen 32x32 multipliers,
// two for the adder tree and one for the shift and clip; the result is offered from the
// last of them, the clip register. A new vertex is accepted every cycle while the output
// side keeps taking results; each stage holds its item under back-pressure, and a stage
// that is empty fills even while the output stalls. Write the matrix only while no
// transaction is in flight.
module vertex_transform_4x4_unit import vt4_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Vertex input
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ELEM_W-1:0]    in_x_i,
  input  logic [ELEM_W-1:0]    in_y_i,
  input  logic [ELEM_W-1:0]    in_z_i,
  input  logic [ELEM_W-1:0]    in_w_i,
  // Transformed vertex
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ELEM_W-1:0]    out_x_o,
  output logic [ELEM_W-1:0]    out_y_o,
  output logic [ELEM_W-1:0]    out_z_o,
  output logic [ELEM_W-1:0]    out_w_o,
  output logic                 saturated_o,
  // Matrix write port
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_data_i
);

  ctrl_t                   ctrl;
  coef_mat_t               coef;
  vec_t                    vec;
  logic [VEC_LEN-1:0][ELEM_W-1:0] res;
  logic [VEC_LEN-1:0]      sat;

  assign vec = {in_w_i, in_z_i, in_y_i, in_x_i};

  vt4_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctrl_o      (ctrl)
  );

  vt4_coef_regs #(
    .FRAC_BITS (FRAC_BITS)
  ) u_coef (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .coef_o     (coef)
  );

  // Lane i takes matrix row i: elements i, 4+i, 8+i, 12+i
  for (genvar i = 0; i < VEC_LEN; i++) begin : g_lane
    vec_t lane_coef;

    always_comb begin
      for (int j = 0; j < VEC_LEN; j++) begin
        lane_coef[j] = coef[VEC_LEN*j + i];
      end
    end

    vt4_dot_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .vec_i  (vec),
      .coef_i (lane_coef),
      .res_o  (res[i]),
      .sat_o  (sat[i])
    );
  end

  assign out_x_o     = res[0];
  assign out_y_o     = res[1];
  assign out_z_o     = res[2];
  assign out_w_o     = res[3];
  assign saturated_o = |sat;

endmodule

[rtl/vt4_checker.sv]
// Port-level checks of the vertex transform, bound to the top level.
`include "vertex_transform_4x4_unit_macros.svh"

module vt4_checker import vt4_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [ELEM_W-1:0]    out_x_o,
  input logic [ELEM_W-1:0]    out_y_o,
  input logic [ELEM_W-1:0]    out_z_o,
  input logic [ELEM_W-1:0]    out_w_o,
  input logic                 saturated_o
);

  logic                      stalled;
  logic                      at_limit;
  logic [VEC_LEN*ELEM_W:0]   out_word;

  assign stalled  = out_valid_o && !out_ready_i;
  assign out_word = {saturated_o, out_w_o, out_z_o, out_y_o, out_x_o};
  assign at_limit = (out_x_o == SAT_MAX) || (out_x_o == SAT_MIN) ||
                    (out_y_o == SAT_MAX) || (out_y_o == SAT_MIN) ||
                    (out_z_o == SAT_MAX) || (out_z_o == SAT_MIN) ||
                    (out_w_o == SAT_MAX) || (out_w_o == SAT_MIN);

  // A stalled result stays offered
  `VT4_ASSERT_NEXT(a_out_hold, stalled, out_valid_o)
  // ...and unchanged
  `VT4_ASSERT_NEXT(a_out_stable, stalled, $stable(out_word))
  // An empty output stage never blocks the input
  `VT4_ASSERT_NOW(a_ready_when_drained, !out_valid_o, in_ready_o)
  // The clip flag implies at least one component sits at a limit
  `VT4_ASSERT_NOW(a_sat_at_limit, out_valid_o && saturated_o, at_limit)

endmodule

bind vertex_transform_4x4_unit vt4_checker u_vt4_checker (.*);

[bench/tb_vertex_transform_4x4_unit.sv]
// Testbench for vertex_transform_4x4_unit: directed table, random phases, self-checking.
`timescale 1ns / 100ps

module tb_vertex_transform_4x4_unit;
  import vt4_pkg::*;

  localparam int unsigned FRAC            = FRAC_BITS_DEF;
  localparam int unsigned DIR_ROWS        = 22;
  localparam int unsigned RAND_PHASES     = 10;
  localparam int unsigned ITEMS_PER_PHASE = 115;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned DRAIN_LIMIT     = 5000;

  localparam logic [ELEM_W-1:0] FIXED_ONE = ELEM_W'(1) << FRAC;
  localparam logic [ELEM_W-1:0] FIXED_TWO = ELEM_W'(2) << FRAC;
  localparam logic [ELEM_W-1:0] NEG_ONE   = -FIXED_ONE;

  // Matrix settings used by the directed table and the random phases
  typedef enum logic [2:0] {
    MAT_IDENT, MAT_MAX, MAT_MIN, MAT_TWO, MAT_FULL, MAT_GFX, MAT_SPARSE, MAT_EXTREME
  } mat_sel_e;

  typedef logic [NUM_REGS-1:0][REG_W-1:0] coef_bank_t;

  typedef struct packed {
    vec_t comp;
    logic sat;
  } tf_result_t;

  typedef struct packed {
    mat_sel_e   mat;
    vec_t       vin;
    logic       typed;
    tf_result_t want;
  } dir_row_t;

  // DUT ports
  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [ELEM_W-1:0]    in_x_i, in_y_i, in_z_i, in_w_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [ELEM_W-1:0]    out_x_o, out_y_o, out_z_o, out_w_o;
  logic                 saturated_o;
  logic                 cfg_we_i;
  logic [REG_IDX_W-1:0] cfg_idx_i;
  logic [REG_W-1:0]     cfg_data_i;

  // Bench state
  tf_result_t expected_vertices [$];
  coef_bank_t matrix_model;
  mat_sel_e   cur_mat;
  logic       row_typed;
  tf_result_t row_want;
  dir_row_t   dir_rows [DIR_ROWS];
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  logic        sender_eager = 1'b0;
  vec_t        accepted_vec;
  tf_result_t  observed, oldest;
  string       comp_label [VEC_LEN] = '{"out_x", "out_y", "out_z", "out_w"};

  vertex_transform_4x4_unit #(
    .FRAC_BITS (FRAC)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_x_i      (in_x_i),
    .in_y_i      (in_y_i),
    .in_z_i      (in_z_i),
    .in_w_i      (in_w_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o),
    .out_w_o     (out_w_o),
    .saturated_o (saturated_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Expected transform: exact sum of four products, floor shift, clip to 32 bits
  function automatic tf_result_t transform_vertex(vec_t v, coef_bank_t m);
    tf_result_t          r;
    logic signed [127:0] acc;
    logic [REG_W-1:0]    pair;
    elem_t               c;
    longint              prod;
    r.sat = 1'b0;
    for (int i = 0; i < VEC_LEN; i++) begin
      acc = '0;
      for (int j = 0; j < VEC_LEN; j++) begin
        pair = m[(4 * j + i) >> 1];
        c    = ((4 * j + i) & 1) ? pair[63:32] : pair[31:0];
        prod = longint'(v[j]) * longint'(c);
        acc  = acc + prod;
      end
      acc = acc >>> FRAC;
      if (acc[127:31] == {97{acc[127]}}) begin
        r.comp[i] = acc[31:0];
      end else begin
        r.sat     = 1'b1;
        r.comp[i] = acc[127] ? SAT_MIN : SAT_MAX;
      end
    end
    return r;
  endfunction

  function automatic vec_t vtx(elem_t x, elem_t y, elem_t z, elem_t w);
    vec_t v;
    v[0] = x;
    v[1] = y;
    v[2] = z;
    v[3] = w;
    return v;
  endfunction

  function automatic dir_row_t mk_row(mat_sel_e mat, vec_t vin, logic typed, vec_t wv,
                                      logic ws);
    dir_row_t r;
    r.mat       = mat;
    r.vin       = vin;
    r.typed     = typed;
    r.want.comp = wv;
    r.want.sat  = ws;
    return r;
  endfunction

  // Uniform value in +/- mag (raw fixed-point units)
  function automatic elem_t small_fixed(int unsigned mag);
    return elem_t'(longint'($urandom_range(0, 2 * mag)) - longint'(mag));
  endfunction

  function automatic elem_t pick_extreme();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return elem_t'(1);
      2:       return '1;
      3:       return SAT_MAX;
      4:       return SAT_MIN;
      5:       return FIXED_ONE;
      default: return NEG_ONE;
    endcase
  endfunction

  // Column-major element n sits in pair n/2, low half for even n
  function automatic coef_bank_t coef_bank_for(mat_sel_e sel);
    coef_mat_t  e;
    coef_bank_t bank;
    for (int n = 0; n < NUM_ELEMS; n++) begin
      case (sel)
        MAT_IDENT:  e[n] = (n / 4 == n % 4) ? FIXED_ONE : '0;
        MAT_MAX:    e[n] = SAT_MAX;
        MAT_MIN:    e[n] = SAT_MIN;
        MAT_TWO:    e[n] = (n / 4 == n % 4) ? FIXED_TWO : '0;
        MAT_FULL:   e[n] = $urandom;
        MAT_GFX:    e[n] = small_fixed(4 << FRAC);
        MAT_SPARSE: e[n] = $urandom_range(0, 1) ? elem_t'($urandom) : '0;
        default:    e[n] = pick_extreme();
      endcase
    end
    for (int k = 0; k < NUM_REGS; k++) begin
      bank[k] = {e[2 * k + 1], e[2 * k]};
    end
    return bank;
  endfunction

  function automatic vec_t random_vertex();
    int unsigned sel;
    vec_t        v;
    sel = $urandom_range(0, 9);
    for (int c = 0; c < VEC_LEN; c++) begin
      if (sel < 4) begin
        v[c] = $urandom;
      end else if (sel < 8) begin
        v[c] = (c == 3) ? FIXED_ONE : small_fixed(1000 << FRAC);
      end else begin
        v[c] = pick_extreme();
      end
    end
    return v;
  endfunction

  // Sender: bursts of random length, random gaps unless eager
  task automatic send_vertex(vec_t v, logic typed, tf_result_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (sender_eager || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_x_i     <= v[0];
    in_y_i     <= v[1];
    in_z_i     <= v[2];
    in_w_i     <= v[3];
    row_typed  <= typed;
    row_want   <= want;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Wait until every transaction in flight has come out
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_vertices.size() != 0) @(posedge clk_i);
    repeat (STAGES + 2) @(posedge clk_i);
  endtask

  task automatic switch_matrix(mat_sel_e sel);
    coef_bank_t bank;
    drain_pipeline();
    bank = coef_bank_for(sel);
    for (int k = 0; k < NUM_REGS; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= REG_IDX_W'(k);
      cfg_data_i <= bank[k];
      @(posedge clk_i);
    end
    cfg_we_i     <= 1'b0;
    matrix_model  = bank;
    cur_mat       = sel;
  endtask

  task automatic report_mismatch(string what, logic [ELEM_W-1:0] want_v,
                                 logic [ELEM_W-1:0] got_v);
    mismatches++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want_v, got_v);
  endtask

  // Scoreboard: record each input transaction, check each output transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        accepted_vec = vtx(in_x_i, in_y_i, in_z_i, in_w_i);
        expected_vertices.push_back(row_typed ? row_want
                                              : transform_vertex(accepted_vec, matrix_model));
      end
      if (out_valid_o && out_ready_i) begin
        observed.comp = vtx(out_x_o, out_y_o, out_z_o, out_w_o);
        observed.sat  = saturated_o;
        if (expected_vertices.size() == 0) begin
          report_mismatch("unexpected result transaction, out_x", 'x, out_x_o);
        end else begin
          oldest = expected_vertices.pop_front();
          for (int c = 0; c < VEC_LEN; c++) begin
            if (observed.comp[c] !== oldest.comp[c]) begin
              report_mismatch(comp_label[c], oldest.comp[c], observed.comp[c]);
            end
          end
          if (observed.sat !== oldest.sat) begin
            report_mismatch("saturated", ELEM_W'(oldest.sat), ELEM_W'(observed.sat));
          end
        end
      end
    end
  end

  // Receiver: random stall patterns, sometimes always ready
  initial begin
    int unsigned ready_pattern;
    int unsigned pat_step;
    out_ready_i   = 1'b0;
    ready_pattern = '1;
    pat_step      = 0;
    forever begin
      @(posedge clk_i);
      if (pat_step % 64 == 0) begin
        case ($urandom_range(0, 3))
          0:       ready_pattern = '1;
          1:       ready_pattern = $urandom | 32'd1;
          2:       ready_pattern = $urandom | $urandom;
          default: ready_pattern = ($urandom & $urandom) | 32'd1;
        endcase
      end
      out_ready_i <= ready_pattern[pat_step % 32];
      pat_step++;
    end
  end

  // Watchdog
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Main sequence
  initial begin
    dir_row_t    r;
    mat_sel_e    rand_styles [4];
    int unsigned waited;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_x_i       = '0;
    in_y_i       = '0;
    in_z_i       = '0;
    in_w_i       = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    row_typed    = 1'b0;
    row_want     = '0;
    matrix_model = coef_bank_for(MAT_IDENT);
    cur_mat      = MAT_IDENT;
    rand_styles  = '{MAT_FULL, MAT_GFX, MAT_SPARSE, MAT_EXTREME};

    // Directed rows; typed expectations where the answer is obvious
    dir_rows = '{
      // identity after reset: output equals input
      mk_row(MAT_IDENT, vtx('0, '0, '0, '0), 1'b1, vtx('0, '0, '0, '0), 1'b0),
      mk_row(MAT_IDENT, vtx(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX), 1'b1,
             vtx(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX), 1'b0),
      mk_row(MAT_IDENT, vtx(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN), 1'b1,
             vtx(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN), 1'b0),
      mk_row(MAT_IDENT, vtx(FIXED_ONE, NEG_ONE, 32'h1234_5678, FIXED_ONE), 1'b1,
             vtx(FIXED_ONE, NEG_ONE, 32'h1234_5678, FIXED_ONE), 1'b0),
      mk_row(MAT_IDENT, vtx('1, '1, '1, '1), 1'b1, vtx('1, '1, '1, '1), 1'b0),
      // all elements at the positive limit: overflow both ways, floor of negatives
      mk_row(MAT_MAX, vtx(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX), 1'b1,
             vtx(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX), 1'b1),
      mk_row(MAT_MAX, vtx(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN), 1'b1,
             vtx(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN), 1'b1),
      mk_row(MAT_MAX, vtx('0, '0, '0, '0), 1'b1, vtx('0, '0, '0, '0), 1'b0),
      mk_row(MAT_MAX, vtx(32'd1, '0, '0, '0), 1'b1,
             vtx(32'h0000_7FFF, 32'h0000_7FFF, 32'h0000_7FFF, 32'h0000_7FFF), 1'b0),
      mk_row(MAT_MAX, vtx('1, '0, '0, '0), 1'b1,
             vtx(32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000), 1'b0),
      mk_row(MAT_MAX, vtx(FIXED_ONE, FIXED_TWO, NEG_ONE, FIXED_ONE), 1'b0, '0, 1'b0),
      // all elements at the negative limit
      mk_row(MAT_MIN, vtx(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN), 1'b1,
             vtx(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX), 1'b1),
      mk_row(MAT_MIN, vtx(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX), 1'b1,
             vtx(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN), 1'b1),
      mk_row(MAT_MIN, vtx(32'd1, '0, '0, '0), 1'b1,
             vtx(32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000), 1'b0),
      mk_row(MAT_MIN, vtx('1, '0, '0, '0), 1'b1,
             vtx(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000), 1'b0),
      mk_row(MAT_MIN, vtx('0, '0, '0, FIXED_ONE), 1'b1,
             vtx(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN), 1'b0),
      // diagonal 2.0: results right at and just past the clip bounds
      mk_row(MAT_TWO, vtx(32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000),
             1'b1, vtx(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX), 1'b1),
      mk_row(MAT_TWO, vtx(32'h3FFF_FFFF, 32'hC000_0000, 32'hBFFF_FFFF, '0), 1'b1,
             vtx(32'h7FFF_FFFE, SAT_MIN, SAT_MIN, '0), 1'b1),
      mk_row(MAT_TWO, vtx(32'h3FFF_FFFF, 32'hC000_0000, '0, FIXED_ONE), 1'b1,
             vtx(32'h7FFF_FFFE, SAT_MIN, '0, FIXED_TWO), 1'b0),
      mk_row(MAT_TWO, vtx(32'h0DEA_DBEE, 32'hF0F0_F0F0, 32'd3, 32'hFFFF_FFFD), 1'b0,
             '0, 1'b0),
      // arbitrary matrix
      mk_row(MAT_FULL, vtx(32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hC3C3_C3C3, 32'h3C3C_3C3C),
             1'b0, '0, 1'b0),
      mk_row(MAT_FULL, vtx(FIXED_ONE, FIXED_ONE, FIXED_ONE, FIXED_ONE), 1'b0, '0, 1'b0)
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: rewrite the matrix whenever the table asks for another
    for (int n = 0; n < DIR_ROWS; n++) begin
      r = dir_rows[n];
      if (r.mat != cur_mat) begin
        switch_matrix(r.mat);
      end
      send_vertex(r.vin, r.typed, r.want);
    end

    // Random part: a fresh matrix per phase, some phases with no sender gaps
    for (int p = 0; p < RAND_PHASES; p++) begin
      switch_matrix(rand_styles[p % 4]);
      sender_eager = (p % 3 == 1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_vertex(random_vertex(), 1'b0, '0);
      end
    end

    // Let the pipeline empty, then allow a tail for stray results
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    waited = 0;
    while (expected_vertices.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (STAGES * 4) @(posedge clk_i);

    if (mismatches == 0 && expected_vertices.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
